// ===== rtl/wrp_pkg.sv =====
package wrp_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int FRAC_BITS       = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_PICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_SCALE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== rtl/wrp_cell.sv =====
module wrp_cell import wrp_pkg::*; #(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic [WEIGHT_BITS-1:0] load_weight,
  input  logic [WEIGHT_BITS-1:0] weight_in,
  output logic [WEIGHT_BITS-1:0] weight
);

  // rotate takes priority; loads only arrive while the ring sits at home
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (ctrl.shift) begin
      weight <= weight_in;
    end else if (ctrl.load) begin
      weight <= load_weight;
    end
  end

endmodule

// ===== rtl/wrp_sum_mem.sv =====
module wrp_sum_mem import wrp_pkg::*; #(
  parameter int DEPTH     = DEF_MAX_ENTRIES,
  parameter int WIDTH     = DEF_WEIGHT_BITS + $clog2(DEF_MAX_ENTRIES),
  parameter int ADDR_BITS = $clog2(DEF_MAX_ENTRIES)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/weighted_random_pick.sv =====
// Roulette-wheel selector. Each entry's weight sits in one cell of a ring of
// MAX_ENTRIES cells; a load word (tuser = 0) writes one cell and returns
// nothing. A pick word (tuser = 1) rotates the ring once around while an
// accumulator at the head cell forms the running sums of the first
// entries_in_use weights into a sum memory, then scales the random fraction
// by the total, then binary-searches the sums, each probe a registered memory
// read and a compare, at most ceil(log2(entries_in_use)) probes, and then
// posts the result. The ring rotation dominates the time of a pick.
// Input is not taken while a pick is in progress. entries_in_use of 0 acts
// as 1 and values above MAX_ENTRIES act as MAX_ENTRIES; write it only while
// the block is idle.
module weighted_random_pick import wrp_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  localparam int IDX_BITS      = $clog2(MAX_ENTRIES),
  localparam int CNT_BITS      = $clog2(MAX_ENTRIES + 1),
  localparam int SUM_BITS      = WEIGHT_BITS + IDX_BITS,
  localparam int IN_DATA_BITS  = ((IDX_BITS + WEIGHT_BITS + FRAC_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_BITS = ((IDX_BITS + SUM_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // entry_index, weight, random_fraction (from bit 0 up), zero padded
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // operation
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // chosen_index, weight_sum (from bit 0 up), zero padded
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  input  logic                     cfg_wr_en,
  input  logic [CNT_BITS-1:0]      cfg_wr_data
);

  state_t state, state_next;

  logic [CNT_BITS-1:0]    entries_in_use;
  logic [CNT_BITS-1:0]    n;
  logic [CNT_BITS-1:0]    n_act;
  logic [IDX_BITS-1:0]    step;
  logic [SUM_BITS-1:0]    acc;
  logic [SUM_BITS-1:0]    acc_next;
  logic [FRAC_BITS-1:0]   frac;
  logic [SUM_BITS-1:0]    target;
  logic [FRAC_BITS+SUM_BITS-1:0] product;
  logic [IDX_BITS-1:0]    lo, hi, mid, mid_r, pick;
  logic [IDX_BITS-1:0]    lo_next, hi_next;
  logic [SUM_BITS-1:0]    rd_sum;
  logic                   match;
  logic                   out_valid;
  logic [IDX_BITS-1:0]    out_index;
  logic [SUM_BITS-1:0]    out_sum;

  logic [IDX_BITS-1:0]    in_index;
  logic [WEIGHT_BITS-1:0] in_weight;
  logic [FRAC_BITS-1:0]   in_frac;
  logic                   in_take;

  logic                   ring_shift;
  logic                   step_in_use;
  logic                   last_step;
  logic                   sum_we;
  logic                   rd_en;
  logic                   out_load;

  logic [WEIGHT_BITS-1:0] ring [MAX_ENTRIES];

  assign in_index  = s_tdata[IDX_BITS-1:0];
  assign in_weight = s_tdata[IDX_BITS +: WEIGHT_BITS];
  assign in_frac   = s_tdata[IDX_BITS+WEIGHT_BITS +: FRAC_BITS];
  assign in_take   = s_tvalid && s_tready;

  assign n_act = (entries_in_use == '0) ? CNT_BITS'(1) :
                 (entries_in_use > CNT_BITS'(MAX_ENTRIES)) ? CNT_BITS'(MAX_ENTRIES) :
                 entries_in_use;

  assign step_in_use = CNT_BITS'(step) < n;
  assign last_step   = step == IDX_BITS'(MAX_ENTRIES - 1);
  assign acc_next    = acc + SUM_BITS'(ring[0]);
  assign mid         = lo + ((hi - lo) >> 1);
  assign match       = rd_sum == target;
  assign product     = frac * acc;

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (rd_sum > target) begin
      hi_next = mid_r;
    end else begin
      lo_next = mid_r + IDX_BITS'(1);
    end
  end

  // weight ring: cell i takes from cell i+1, so the head sees entry k at step k
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.shift = ring_shift;
    assign ctrl.load  = in_take && (s_tuser == OP_LOAD) && (in_index == IDX_BITS'(i));
    wrp_cell #(
      .WEIGHT_BITS(WEIGHT_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .load_weight (in_weight),
      .weight_in   (ring[(i + 1) % MAX_ENTRIES]),
      .weight      (ring[i])
    );
  end

  wrp_sum_mem #(
    .DEPTH     (MAX_ENTRIES),
    .WIDTH     (SUM_BITS),
    .ADDR_BITS (IDX_BITS)
  ) u_sum_mem (
    .clk   (clk),
    .we    (sum_we),
    .waddr (step),
    .wdata (acc_next),
    .re    (rd_en),
    .raddr (mid),
    .rdata (rd_sum)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take && (s_tuser == OP_PICK)) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (last_step) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        state_next = (hi != '0) ? S_PROBE : S_DONE;
      end
      S_PROBE: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (match || !(lo_next < hi_next)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    ring_shift = 1'b0;
    sum_we     = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_SUM: begin
        ring_shift = 1'b1;
        sum_we     = step_in_use;
      end
      S_PROBE: rd_en = 1'b1;
      S_DONE:  out_load = !out_valid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entries_in_use <= CNT_BITS'(1);
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        entries_in_use <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        step <= '0;
        acc  <= '0;
        frac <= in_frac;
        n    <= n_act;
        hi   <= IDX_BITS'(n_act - CNT_BITS'(1));
      end
      S_SUM: begin
        step <= step + IDX_BITS'(1);
        if (step_in_use) begin
          acc <= acc_next;
        end
      end
      S_SCALE: begin
        target <= product[FRAC_BITS +: SUM_BITS];
        lo     <= '0;
        pick   <= '0;
      end
      S_PROBE: begin
        mid_r <= mid;
      end
      S_CMP: begin
        lo   <= lo_next;
        hi   <= hi_next;
        pick <= match ? mid_r : lo_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index <= pick;
      out_sum   <= acc;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_BITS'({out_sum, out_index});

endmodule

// ===== rtl/wrp_checker.sv =====
module wrp_checker import wrp_pkg::*; #(
  parameter int OUT_DATA_BITS = 32
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     s_tuser,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata
);

  // a taken pick word closes the input behind it (the design keeps it closed through the ring rotation)
  a_pick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_PICK) |=> !s_tready)
    else $error("input open right after a pick word");

  // a load word leaves the input open behind it
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_LOAD) |=> s_tready)
    else $error("input closed after a load word");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word dropped or changed");

endmodule

bind weighted_random_pick wrp_checker #(
  .OUT_DATA_BITS (OUT_DATA_BITS)
) u_wrp_checker (
  .clk         (clk),
  .rst         (rst),
  .s_tvalid    (s_tvalid),
  .s_tready    (s_tready),
  .s_tuser     (s_tuser),
  .m_tvalid    (m_tvalid),
  .m_tready    (m_tready),
  .m_tdata     (m_tdata)
);
